// File: design/cfd_pkg.sv
package cfd_pkg;

   localparam logic [15:0] CrcPoly        = 16'h1021;
   localparam logic [7:0]  MasterReserved = 8'h1E;

   // Byte positions inside a frame. Position zero doubles as the idle code.
   localparam logic [3:0] PosIdle      = 4'd0;
   localparam logic [3:0] PosSeqLow    = 4'd1;
   localparam logic [3:0] PosSeqHigh   = 4'd2;
   localparam logic [3:0] PosSpeedLow  = 4'd3;
   localparam logic [3:0] PosSpeedHigh = 4'd4;
   localparam logic [3:0] PosSteerLow  = 4'd5;
   localparam logic [3:0] PosSteerHigh = 4'd6;
   localparam logic [3:0] PosMaster    = 4'd7;
   localparam logic [3:0] PosSlave     = 4'd8;
   localparam logic [3:0] PosCrcLow    = 4'd9;
   localparam logic [3:0] PosCrcHigh   = 4'd10;

   typedef enum logic [1:0] {
      CSR_MARKER_VALUE       = 2'd0,
      CSR_COMMAND_LIMIT      = 2'd1,
      CSR_SLAVE_INVALID_MASK = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_BAD_MARKER  = 3'd1,
      STATUS_BAD_CRC     = 3'd2,
      STATUS_SPEED_RANGE = 3'd3,
      STATUS_STEER_RANGE = 3'd4,
      STATUS_MASTER_FLAG = 3'd5,
      STATUS_SLAVE_FLAG  = 3'd6
   } status_type;

   typedef struct packed {
      logic [7:0]  marker_value;
      logic [14:0] command_limit;
      logic [7:0]  slave_invalid_mask;
   } cfg_type;

   typedef struct packed {
      status_type         status;
      logic [15:0]        sequence_number;
      logic signed [15:0] speed_value;
      logic signed [15:0] steer_value;
      logic [7:0]         master_flag_bits;
      logic [7:0]         slave_flag_bits;
   } result_type;

   // One byte of CRC-16, polynomial 0x1021, MSB first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
      end
      return c;
   endfunction

   // True when -limit <= raw <= limit, raw taken as two's complement.
   function automatic logic in_range(input logic [15:0] raw, input logic [14:0] limit);
      logic signed [16:0] v;
      logic signed [16:0] l;
      v = $signed({raw[15], raw});
      l = $signed({2'b00, limit});
      return (v <= l) && (v >= -l);
   endfunction

endpackage

// File: design/command_frame_decoder_crc16.sv
// Decodes 11-byte command frames arriving one byte per transfer on the req
// channel and gives one result on the rsp channel after the final CRC byte.
// A byte flagged with frame_start always begins a new frame; other bytes are
// dropped while no frame is open. The block takes one byte per clock cycle
// while no result is stalled; the CRC-16 update for a whole byte is a single
// combinational step in the frame assembler. A byte is held in the input
// register until no result is stalled, then folded into the frame state; the
// result of a frame is registered in the output register and waits until taken.
// Configuration writes take effect at the next clock edge.
module command_frame_decoder_crc16 import cfd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_frame_start,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [15:0]        rsp_sequence_number,
   output logic signed [15:0] rsp_speed_value,
   output logic signed [15:0] rsp_steer_value,
   output logic [7:0]         rsp_master_flag_bits,
   output logic [7:0]         rsp_slave_flag_bits,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [14:0]        csr_write_data
);

   cfg_type    cfg;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   result_type frame_result;
   logic       frame_done;
   logic       advance;
   logic       step;

   cfd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // The held byte moves on whenever the output register is free or drains now.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   cfd_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .data_byte   (in_byte_ff),
      .frame_start (in_start_ff),
      .cfg         (cfg),
      .done        (frame_done),
      .result      (frame_result)
   );

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (step && frame_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_frame_start;
      end
      if (step && frame_done) begin
         rsp_data_ff <= frame_result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_data_ff.status;
   assign rsp_sequence_number  = rsp_data_ff.sequence_number;
   assign rsp_speed_value      = rsp_data_ff.speed_value;
   assign rsp_steer_value      = rsp_data_ff.steer_value;
   assign rsp_master_flag_bits = rsp_data_ff.master_flag_bits;
   assign rsp_slave_flag_bits  = rsp_data_ff.slave_flag_bits;

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !step)
      else $error("frame state advanced while a result was stalled");

   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff)
      else $error("input stalled with an empty input register");

   assert property (@(posedge clock) disable iff (reset)
      (step && frame_done) |=> rsp_valid_ff)
      else $error("finished frame did not reach the output register");

endmodule

// File: design/cfd_csr.sv
module cfd_csr import cfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_write_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MARKER_VALUE:       cfg_in.marker_value       = csr_write_data[7:0];
            CSR_COMMAND_LIMIT:      cfg_in.command_limit      = csr_write_data;
            CSR_SLAVE_INVALID_MASK: cfg_in.slave_invalid_mask = csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.marker_value       <= 8'd165;
         cfg_ff.command_limit      <= 15'd1000;
         cfg_ff.slave_invalid_mask <= 8'd31;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/cfd_frame.sv
module cfd_frame import cfd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       frame_start,
   input  cfg_type    cfg,
   output logic       done,
   output result_type result
);

   logic [3:0]  byte_position_ff, byte_position_in;
   logic [15:0] running_crc_ff, running_crc_in;
   logic        marker_ok_ff, marker_ok_in;
   logic [15:0] seq_hold_ff, seq_hold_in;
   logic [15:0] speed_hold_ff, speed_hold_in;
   logic [15:0] steer_hold_ff, steer_hold_in;
   logic [7:0]  master_hold_ff, master_hold_in;
   logic [7:0]  slave_hold_ff, slave_hold_in;
   logic [7:0]  crc_low_hold_ff, crc_low_hold_in;

   always_comb begin
      byte_position_in = byte_position_ff;
      running_crc_in   = running_crc_ff;
      marker_ok_in     = marker_ok_ff;
      seq_hold_in      = seq_hold_ff;
      speed_hold_in    = speed_hold_ff;
      steer_hold_in    = steer_hold_ff;
      master_hold_in   = master_hold_ff;
      slave_hold_in    = slave_hold_ff;
      crc_low_hold_in  = crc_low_hold_ff;
      done             = 1'b0;
      if (step) begin
         if (frame_start) begin
            marker_ok_in     = (data_byte == cfg.marker_value);
            running_crc_in   = crc_byte(16'h0000, data_byte);
            byte_position_in = PosSeqLow;
         end else if (byte_position_ff != PosIdle && byte_position_ff <= PosCrcHigh) begin
            if (byte_position_ff <= PosSlave) begin
               running_crc_in   = crc_byte(running_crc_ff, data_byte);
               byte_position_in = byte_position_ff + 4'd1;
            end
            case (byte_position_ff)
               PosSeqLow:    seq_hold_in[7:0]    = data_byte;
               PosSeqHigh:   seq_hold_in[15:8]   = data_byte;
               PosSpeedLow:  speed_hold_in[7:0]  = data_byte;
               PosSpeedHigh: speed_hold_in[15:8] = data_byte;
               PosSteerLow:  steer_hold_in[7:0]  = data_byte;
               PosSteerHigh: steer_hold_in[15:8] = data_byte;
               PosMaster:    master_hold_in      = data_byte;
               PosSlave:     slave_hold_in       = data_byte;
               PosCrcLow: begin
                  crc_low_hold_in  = data_byte;
                  byte_position_in = PosCrcHigh;
               end
               PosCrcHigh: begin
                  byte_position_in = PosIdle;
                  done             = 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   // The checks only matter on the last byte, where data_byte is the CRC high byte.
   always_comb begin
      if (!marker_ok_ff) begin
         result.status = STATUS_BAD_MARKER;
      end else if ({data_byte, crc_low_hold_ff} != running_crc_ff) begin
         result.status = STATUS_BAD_CRC;
      end else if (!in_range(speed_hold_ff, cfg.command_limit)) begin
         result.status = STATUS_SPEED_RANGE;
      end else if (!in_range(steer_hold_ff, cfg.command_limit)) begin
         result.status = STATUS_STEER_RANGE;
      end else if ((master_hold_ff & MasterReserved) != 8'h00) begin
         result.status = STATUS_MASTER_FLAG;
      end else if ((slave_hold_ff & cfg.slave_invalid_mask) != 8'h00) begin
         result.status = STATUS_SLAVE_FLAG;
      end else begin
         result.status = STATUS_OK;
      end
      result.sequence_number  = seq_hold_ff;
      result.speed_value      = $signed(speed_hold_ff);
      result.steer_value      = $signed(steer_hold_ff);
      result.master_flag_bits = master_hold_ff;
      result.slave_flag_bits  = slave_hold_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= PosIdle;
      end else begin
         byte_position_ff <= byte_position_in;
      end
   end

   always_ff @(posedge clock) begin
      running_crc_ff  <= running_crc_in;
      marker_ok_ff    <= marker_ok_in;
      seq_hold_ff     <= seq_hold_in;
      speed_hold_ff   <= speed_hold_in;
      steer_hold_ff   <= steer_hold_in;
      master_hold_ff  <= master_hold_in;
      slave_hold_ff   <= slave_hold_in;
      crc_low_hold_ff <= crc_low_hold_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      byte_position_ff <= PosCrcHigh)
      else $error("byte position left the frame range");

   assert property (@(posedge clock) disable iff (reset)
      done |-> (byte_position_ff == PosCrcHigh && !frame_start))
      else $error("result produced away from the last frame byte");

   assert property (@(posedge clock) disable iff (reset)
      (step && frame_start) |=> byte_position_ff == PosSeqLow)
      else $error("start byte did not restart the frame");

endmodule
